// ===== hdl/knn_pkg.sv =====
// Shared constants and types for the nearest-neighbor search block.
package knn_pkg;

  localparam int DEF_NUM_FEATURES  = 8;
  localparam int DEF_NUM_NEIGHBORS = 3;
  localparam int DEF_MAX_ROWS      = 1024;
  localparam int DEF_FEATURE_BITS  = 10;

  localparam int QUERY_REGS     = 8;
  localparam int CFG_INDEX_BITS = 4;
  localparam int DIST_BITS      = 23;

  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  // Control from the row pipeline to the neighbor list.
  typedef struct packed {
    logic advance;
    logic row_valid;
    logic row_last;
  } list_ctl_t;

endpackage

// ===== hdl/knn_lane.sv =====
// One feature lane: absolute difference against the query, then squared.
module knn_lane #(
  parameter int FEATURE_BITS = knn_pkg::DEF_FEATURE_BITS
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [FEATURE_BITS-1:0]     feat,
  input  logic [FEATURE_BITS-1:0]     query,
  output logic [2*FEATURE_BITS-1:0]   sq
);
  import knn_pkg::*;

  logic [FEATURE_BITS-1:0]   diff;
  logic [2*FEATURE_BITS-1:0] diff_ext;

  always_comb begin
    diff     = (feat >= query) ? (feat - query) : (query - feat);
    diff_ext = {{FEATURE_BITS{1'b0}}, diff};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq <= diff_ext * diff_ext;
    end
  end

endmodule

// ===== hdl/knn_merge.sv =====
// Merge stage: sums the lane squares and saturates to the distance width.
module knn_merge #(
  parameter int NUM_FEATURES = knn_pkg::DEF_NUM_FEATURES,
  parameter int FEATURE_BITS = knn_pkg::DEF_FEATURE_BITS
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [2*FEATURE_BITS-1:0]       sq [NUM_FEATURES],
  output logic [knn_pkg::DIST_BITS-1:0]   sq_sum
);
  import knn_pkg::*;

  localparam int RAW_BITS = 2 * FEATURE_BITS + $clog2(NUM_FEATURES) + 1;
  localparam int SUM_BITS = (RAW_BITS > DIST_BITS) ? RAW_BITS : DIST_BITS + 1;

  logic [SUM_BITS-1:0] sum;

  always_comb begin
    sum = '0;
    for (int j = 0; j < NUM_FEATURES; j++) begin
      sum = sum + SUM_BITS'(sq[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_sum <= (sum > SUM_BITS'(DIST_MAX)) ? DIST_MAX : sum[DIST_BITS-1:0];
    end
  end

endmodule

// ===== hdl/knn_list.sv =====
// Sorted list of nearest rows plus the result buffer drained one rank per beat.
module knn_list #(
  parameter int NUM_NEIGHBORS = knn_pkg::DEF_NUM_NEIGHBORS,
  parameter int ID_BITS       = 10,
  parameter int RANK_BITS     = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  knn_pkg::list_ctl_t            ctl,
  input  logic [knn_pkg::DIST_BITS-1:0] row_dist,
  input  logic [ID_BITS-1:0]            row_id,
  output logic                          buf_free,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [RANK_BITS-1:0]          rank,
  output logic [ID_BITS-1:0]            neighbor_id,
  output logic [knn_pkg::DIST_BITS-1:0] squared_distance,
  output logic                          found,
  output logic                          run_end
);
  import knn_pkg::*;

  localparam int CNT_BITS = $clog2(NUM_NEIGHBORS + 1);

  logic [DIST_BITS-1:0] best_dist  [NUM_NEIGHBORS];
  logic [ID_BITS-1:0]   best_id    [NUM_NEIGHBORS];
  logic                 best_valid [NUM_NEIGHBORS];

  logic [DIST_BITS-1:0] dist_next  [NUM_NEIGHBORS];
  logic [ID_BITS-1:0]   id_next    [NUM_NEIGHBORS];
  logic                 valid_next [NUM_NEIGHBORS];
  logic                 ins        [NUM_NEIGHBORS];

  logic [DIST_BITS-1:0] out_dist  [NUM_NEIGHBORS];
  logic [ID_BITS-1:0]   out_id    [NUM_NEIGHBORS];
  logic                 out_valid [NUM_NEIGHBORS];
  logic [CNT_BITS-1:0]  cnt;
  logic [RANK_BITS-1:0] rank_cnt;

  logic take_row;
  logic load_buf;
  logic beat;

  // Valid entries form a sorted prefix, so the insert flags are monotonic.
  always_comb begin
    for (int k = 0; k < NUM_NEIGHBORS; k++) begin
      ins[k] = !best_valid[k] || (row_dist < best_dist[k]);
    end
    for (int k = 0; k < NUM_NEIGHBORS; k++) begin
      if (!ins[k]) begin
        dist_next[k]  = best_dist[k];
        id_next[k]    = best_id[k];
        valid_next[k] = best_valid[k];
      end else if (k == 0 || !ins[(k > 0) ? k - 1 : 0]) begin
        dist_next[k]  = row_dist;
        id_next[k]    = row_id;
        valid_next[k] = 1'b1;
      end else begin
        dist_next[k]  = best_dist[(k > 0) ? k - 1 : 0];
        id_next[k]    = best_id[(k > 0) ? k - 1 : 0];
        valid_next[k] = best_valid[(k > 0) ? k - 1 : 0];
      end
    end
  end

  assign result_valid = (cnt != '0);
  assign beat         = result_valid && !result_stall;
  assign buf_free     = (cnt == '0) || ((cnt == CNT_BITS'(1)) && !result_stall);
  assign take_row     = ctl.advance && ctl.row_valid;
  assign load_buf     = take_row && ctl.row_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_NEIGHBORS; k++) begin
        best_valid[k] <= 1'b0;
      end
    end else if (take_row) begin
      for (int k = 0; k < NUM_NEIGHBORS; k++) begin
        best_valid[k] <= ctl.row_last ? 1'b0 : valid_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_row) begin
      for (int k = 0; k < NUM_NEIGHBORS; k++) begin
        best_dist[k] <= ctl.row_last ? DIST_MAX : dist_next[k];
        best_id[k]   <= ctl.row_last ? '0 : id_next[k];
      end
    end
  end

  // Result buffer: load a snapshot on the final row, shift down on each beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      rank_cnt <= '0;
    end else if (load_buf) begin
      cnt      <= CNT_BITS'(NUM_NEIGHBORS);
      rank_cnt <= '0;
    end else if (beat) begin
      cnt      <= cnt - CNT_BITS'(1);
      rank_cnt <= rank_cnt + RANK_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_buf) begin
      for (int k = 0; k < NUM_NEIGHBORS; k++) begin
        out_dist[k]  <= dist_next[k];
        out_id[k]    <= id_next[k];
        out_valid[k] <= valid_next[k];
      end
    end else if (beat) begin
      for (int k = 0; k < NUM_NEIGHBORS - 1; k++) begin
        out_dist[k]  <= out_dist[k+1];
        out_id[k]    <= out_id[k+1];
        out_valid[k] <= out_valid[k+1];
      end
    end
  end

  assign rank             = rank_cnt;
  assign found            = out_valid[0];
  assign neighbor_id      = out_valid[0] ? out_id[0] : '0;
  assign squared_distance = out_valid[0] ? out_dist[0] : '0;
  assign run_end          = (cnt == CNT_BITS'(1));

endmodule

// ===== hdl/knn_top3_euclidean_search_core.sv =====
// Top level of the three-nearest-neighbor squared-distance search core.
//
//   channel   direction  handshake              payload
//   row       in         row_valid/row_stall    row_f0..row_f7, row_id, final_row
//   result    out        result_valid/stall     rank, neighbor_id, squared_distance,
//                                               found, run_end
//   cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One row a cycle while rows are not stalled: lane squaring, merge sum and list insert
// are three register stages. A final row reaches the list through s1 and s2; its
// NUM_NEIGHBORS results then leave one per result beat from a buffer while further rows flow.
// The row side stalls only when a final row reaches the list while the previous
// set's results are still draining. Reset clears the list, the buffer and the query.
module knn_top3_euclidean_search_core #(
  parameter int NUM_FEATURES  = knn_pkg::DEF_NUM_FEATURES,
  parameter int NUM_NEIGHBORS = knn_pkg::DEF_NUM_NEIGHBORS,
  parameter int MAX_ROWS      = knn_pkg::DEF_MAX_ROWS,
  parameter int FEATURE_BITS  = knn_pkg::DEF_FEATURE_BITS,
  parameter int ID_BITS       = $clog2(MAX_ROWS),
  parameter int RANK_BITS     = (NUM_NEIGHBORS > 1) ? $clog2(NUM_NEIGHBORS) : 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [knn_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [FEATURE_BITS-1:0]            cfg_data,
  input  logic                               row_valid,
  output logic                               row_stall,
  input  logic [FEATURE_BITS-1:0]            row_f0,
  input  logic [FEATURE_BITS-1:0]            row_f1,
  input  logic [FEATURE_BITS-1:0]            row_f2,
  input  logic [FEATURE_BITS-1:0]            row_f3,
  input  logic [FEATURE_BITS-1:0]            row_f4,
  input  logic [FEATURE_BITS-1:0]            row_f5,
  input  logic [FEATURE_BITS-1:0]            row_f6,
  input  logic [FEATURE_BITS-1:0]            row_f7,
  input  logic [ID_BITS-1:0]                 row_id,
  input  logic                               final_row,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [RANK_BITS-1:0]               rank,
  output logic [ID_BITS-1:0]                 neighbor_id,
  output logic [knn_pkg::DIST_BITS-1:0]      squared_distance,
  output logic                               found,
  output logic                               run_end
);
  import knn_pkg::*;

  localparam int QIDX_BITS = $clog2(QUERY_REGS);

  logic [FEATURE_BITS-1:0]   query    [QUERY_REGS];
  logic [FEATURE_BITS-1:0]   row_feat [QUERY_REGS];
  logic [2*FEATURE_BITS-1:0] sq       [NUM_FEATURES];
  logic [DIST_BITS-1:0]      s2_dist;

  logic               s1_valid;
  logic               s1_last;
  logic [ID_BITS-1:0] s1_id;
  logic               s2_valid;
  logic               s2_last;
  logic [ID_BITS-1:0] s2_id;

  logic      advance;
  logic      buf_free;
  list_ctl_t ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QUERY_REGS; k++) begin
        query[k] <= '0;
      end
    end else if (cfg_valid && cfg_ready &&
                 (cfg_index < CFG_INDEX_BITS'(QUERY_REGS))) begin
      query[cfg_index[QIDX_BITS-1:0]] <= cfg_data;
    end
  end

  always_comb begin
    row_feat[0] = row_f0;
    row_feat[1] = row_f1;
    row_feat[2] = row_f2;
    row_feat[3] = row_f3;
    row_feat[4] = row_f4;
    row_feat[5] = row_f5;
    row_feat[6] = row_f6;
    row_feat[7] = row_f7;
  end

  // Hold the whole pipe while a final row waits for the result buffer.
  assign advance   = !(s2_valid && s2_last && !buf_free);
  assign row_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= row_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_id   <= row_id;
      s1_last <= final_row;
      s2_id   <= s1_id;
      s2_last <= s1_last;
    end
  end

  for (genvar j = 0; j < NUM_FEATURES; j++) begin : g_lane
    knn_lane #(
      .FEATURE_BITS(FEATURE_BITS)
    ) u_lane (
      .clk   (clk),
      .en    (advance),
      .feat  (row_feat[j]),
      .query (query[j]),
      .sq    (sq[j])
    );
  end

  knn_merge #(
    .NUM_FEATURES(NUM_FEATURES),
    .FEATURE_BITS(FEATURE_BITS)
  ) u_merge (
    .clk    (clk),
    .en     (advance),
    .sq     (sq),
    .sq_sum (s2_dist)
  );

  always_comb begin
    ctl.advance   = advance;
    ctl.row_valid = s2_valid;
    ctl.row_last  = s2_last;
  end

  knn_list #(
    .NUM_NEIGHBORS(NUM_NEIGHBORS),
    .ID_BITS      (ID_BITS),
    .RANK_BITS    (RANK_BITS)
  ) u_list (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .row_dist         (s2_dist),
    .row_id           (s2_id),
    .buf_free         (buf_free),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .rank             (rank),
    .neighbor_id      (neighbor_id),
    .squared_distance (squared_distance),
    .found            (found),
    .run_end          (run_end)
  );

  // A run of results never breaks off before its last rank.
  a_run_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !run_end |=> result_valid)
    else $error("result run ended early");

  // The last beat of a run carries the highest rank.
  a_last_rank: assert property (@(posedge clk) disable iff (rst)
    result_valid && run_end |-> rank == RANK_BITS'(NUM_NEIGHBORS - 1))
    else $error("run_end on wrong rank");

  // Rows stall only behind a final row while results are still pending.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    row_stall |-> s2_valid && s2_last && result_valid)
    else $error("row side stalled without cause");

  // A run starts at rank zero.
  a_first_rank: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> rank == '0)
    else $error("run did not start at rank zero");

endmodule
